@@ src/vdic_pkg.sv @@
// Shared types and constants of the point-plot display controller.
// Used by vdic_step, vdic_outq and vector_display_iot_controller; no dependencies.
`default_nettype none

package vdic_pkg;

	// Field widths fixed by the machine word and the display.
	localparam int WORD_W  = 18;
	localparam int COORD_W = 10;
	localparam int INT_W   = 3;
	localparam int CNT_W   = 6;
	localparam int APER_W  = 6;
	localparam int RAD_W   = 10;

	// Phase codes of the plot sequencer.
	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_DEFL = 2'd1;
	localparam logic [1:0] PH_DRAW = 2'd2;

	// Instruction decode patterns.
	localparam logic [10:0] APER_MASK  = 11'o3777;
	localparam logic [10:0] APER_CODE  = 11'o3407;
	localparam logic [3:0]  SDB_CODE   = 4'b0010;
	localparam logic [APER_W-1:0] APER_MIN = 6'd6;

	localparam logic [APER_W-1:0] APER_RESET = 6'd6;
	localparam logic [RAD_W-1:0]  RAD_RESET  = 10'd9;

	// Result queue geometry.
	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;
	localparam int QCNT_W = 3;

	typedef struct packed {
		logic lightpen;
		logic sdb;
		logic shift;
		logic twoscreen;
	} vdic_cfg_t;

	typedef struct packed {
		logic              req_type;
		logic              has_pulse;
		logic              wants_completion;
		logic [WORD_W-1:0] instr_word;
		logic [WORD_W-1:0] ac_word;
		logic [WORD_W-1:0] io_word;
	} vdic_in_t;

	typedef struct packed {
		logic [1:0]         phase;
		logic [CNT_W-1:0]   countdown;
		logic [COORD_W-1:0] cur_x;
		logic [COORD_W-1:0] cur_y;
		logic [INT_W-1:0]   cur_int;
		logic               pending;
		logic [APER_W-1:0]  aperture;
		logic [RAD_W-1:0]   radius_sq;
	} vdic_state_t;

	typedef struct packed {
		logic               dot_valid;
		logic               screen;
		logic [COORD_W-1:0] dot_x;
		logic [COORD_W-1:0] dot_y;
		logic [INT_W-1:0]   dot_intensity;
		logic               pen_check;
		logic [RAD_W-1:0]   pen_radius_sq;
		logic               complete_pulse;
		logic               clear_pen_flag;
		logic               last;
	} vdic_res_t;

endpackage

`default_nettype wire

@@ src/vdic_step.sv @@
// Next-state and result decode for one word of the display controller.
// Depends on vdic_pkg.
`default_nettype none

module vdic_step #(
	parameter int MOVE_TICKS = 30,
	parameter int DRAW_TICKS = 5
) (
	input  wire vdic_pkg::vdic_cfg_t   cfg,
	input  wire vdic_pkg::vdic_in_t    item,
	input  wire vdic_pkg::vdic_state_t cur,
	output vdic_pkg::vdic_state_t      nxt,
	output logic [1:0]                 nres,
	output vdic_pkg::vdic_res_t        res0,
	output vdic_pkg::vdic_res_t        res1
);

	localparam logic [vdic_pkg::CNT_W-1:0] MOVE_CNT = vdic_pkg::CNT_W'(MOVE_TICKS);
	localparam logic [vdic_pkg::CNT_W-1:0] DRAW_CNT = vdic_pkg::CNT_W'(DRAW_TICKS);

	logic [vdic_pkg::CNT_W-1:0]   cnt_dec;
	logic                         two;
	logic                         pend_acc;
	logic                         aper_hit;
	logic                         sdb_hit;
	logic                         no_wait;
	logic [vdic_pkg::APER_W-1:0]  aper_new;
	logic [vdic_pkg::APER_W-2:0]  half;
	logic [vdic_pkg::COORD_W-1:0] lx;
	logic [vdic_pkg::COORD_W-1:0] ly;
	logic [9:0]                   bit9;

	always_comb begin
		cnt_dec  = cur.countdown - 1'b1;
		two      = cfg.twoscreen & cur.cur_int[2];
		pend_acc = cur.pending | item.wants_completion;
		aper_hit = cfg.lightpen &&
			((item.instr_word[10:0] & vdic_pkg::APER_MASK) == vdic_pkg::APER_CODE);
		sdb_hit  = cfg.sdb && (item.instr_word[12:9] == vdic_pkg::SDB_CODE);
		no_wait  = aper_hit | sdb_hit;
		aper_new = (item.io_word[5:0] < vdic_pkg::APER_MIN) ? vdic_pkg::APER_MIN
			: item.io_word[5:0];
		half     = aper_new[vdic_pkg::APER_W-1:1];
		bit9     = 10'b10_0000_0000;
		lx       = item.ac_word[17:8];
		ly       = item.io_word[17:8];
		if (cfg.shift && !cfg.sdb) begin
			if (item.instr_word[9])  ly = ly ^ bit9;
			if (item.instr_word[10]) lx = lx ^ bit9;
		end

		nxt  = cur;
		nres = 2'd0;
		res0 = '0;
		res1 = '0;
		res0.pen_radius_sq = cur.radius_sq;
		res0.last          = 1'b1;

		if (item.req_type) begin
			// Microsecond tick.
			if (cur.countdown != '0) begin
				nxt.countdown = cnt_dec;
				if (cnt_dec == '0) begin
					if (cur.phase == vdic_pkg::PH_DEFL) begin
						nxt.phase     = vdic_pkg::PH_DRAW;
						nxt.countdown = DRAW_CNT;
					end else begin
						nxt.phase   = vdic_pkg::PH_IDLE;
						nxt.pending = 1'b0;
						nres        = two ? 2'd2 : 2'd1;
						res0.dot_valid      = 1'b1;
						res0.dot_x          = cur.cur_x;
						res0.dot_y          = cur.cur_y;
						res0.dot_intensity  = cur.cur_int;
						res0.pen_check      = cfg.lightpen;
						res0.complete_pulse = two ? 1'b0 : cur.pending;
						res0.last           = ~two;
						res1 = res0;
						res1.screen         = 1'b1;
						res1.dot_intensity  = {1'b0, cur.cur_int[1:0]};
						res1.pen_check      = 1'b0;
						res1.complete_pulse = cur.pending;
						res1.last           = 1'b1;
						if (two) nxt.cur_int = {1'b0, cur.cur_int[1:0]};
					end
				end
			end
		end else begin
			nres        = 2'd1;
			nxt.pending = pend_acc;
			if (!item.has_pulse) begin
				// Clear coordinates; the scheduled countdown keeps running.
				nxt.cur_x   = '0;
				nxt.cur_y   = '0;
				nxt.cur_int = '0;
				nxt.phase   = vdic_pkg::PH_DRAW;
				res0.clear_pen_flag = cfg.lightpen;
			end else begin
				if (aper_hit) begin
					nxt.aperture  = aper_new;
					nxt.radius_sq = vdic_pkg::RAD_W'(half) * vdic_pkg::RAD_W'(half);
				end else begin
					nxt.cur_x   = lx;
					nxt.cur_y   = ly;
					nxt.cur_int = item.instr_word[8:6];
				end
				if (no_wait) begin
					nxt.phase     = vdic_pkg::PH_IDLE;
					nxt.countdown = '0;
					nxt.pending   = 1'b0;
					res0.complete_pulse = pend_acc;
				end else begin
					nxt.phase     = vdic_pkg::PH_DEFL;
					nxt.countdown = MOVE_CNT;
				end
				res0.pen_radius_sq = nxt.radius_sq;
			end
		end
	end

endmodule

`default_nettype wire

@@ src/vdic_outq.sv @@
// Result queue of the display controller: takes up to two words a cycle, gives one.
// Depends on vdic_pkg.
`default_nettype none

module vdic_outq (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire [1:0]                 wr_n,
	input  wire vdic_pkg::vdic_res_t  wr0,
	input  wire vdic_pkg::vdic_res_t  wr1,
	input  wire                       pop,
	output logic                      not_empty,
	output logic                      room2,
	output vdic_pkg::vdic_res_t       head,
	output logic [vdic_pkg::QCNT_W-1:0] count
);

	vdic_pkg::vdic_res_t            mem_q [vdic_pkg::QDEPTH];
	logic [vdic_pkg::QPTR_W-1:0]    wr_ptr_q;
	logic [vdic_pkg::QPTR_W-1:0]    rd_ptr_q;
	logic [vdic_pkg::QCNT_W-1:0]    cnt_q;
	logic [vdic_pkg::QPTR_W-1:0]    wr_ptr1;

	function automatic logic [vdic_pkg::QPTR_W-1:0] QPTR_STEP(input logic [1:0] n);
		QPTR_STEP = vdic_pkg::QPTR_W'(n);
	endfunction

	assign wr_ptr1   = wr_ptr_q + 1'b1;
	assign not_empty = (cnt_q != '0);
	assign room2     = (cnt_q <= vdic_pkg::QCNT_W'(vdic_pkg::QDEPTH - 2));
	assign head      = mem_q[rd_ptr_q];
	assign count     = cnt_q;

	always_ff @(posedge clk) begin
		if (wr_n != 2'd0) mem_q[wr_ptr_q] <= wr0;
		if (wr_n == 2'd2) mem_q[wr_ptr1] <= wr1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + QPTR_STEP(wr_n);
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			cnt_q <= cnt_q + {1'b0, wr_n} - {{(vdic_pkg::QCNT_W-1){1'b0}}, pop};
		end
	end

endmodule

`default_nettype wire

@@ src/vector_display_iot_controller.sv @@
// Top level of the point-plot display controller: input register, plot state,
// configuration port and result queue. Depends on vdic_pkg, vdic_step, vdic_outq.
//
//  channel   direction  handshake            payload
//  input     in         in_valid / in_stall  req_type .. io_word (one word per access/tick)
//  output    out        out_valid / out_stall dot_valid .. last (0 to 2 words per input)
//  config    in/out     APB psel/penable     paddr[3:2] selects the enable bit
//
// An input word is taken into a register and, once the queue has room for two
// results, one pass of decode logic updates the plot state and pushes zero,
// one or two result words into a four-entry queue; a word can be taken every
// cycle while in_stall is low, and its results reach the output from the queue head.
// in_stall rises only while the registered word waits for two free queue
// entries, so a stalled output side holds back the input once three or four
// words that cause results have been accepted.
// Reset clears the enables, the sequencer to idle with no countdown, the
// coordinates, the pending completion, and sets the aperture to six and the radius square to nine.
`default_nettype none

module vector_display_iot_controller #(
	parameter int MOVE_TICKS = 30,
	parameter int DRAW_TICKS = 5
) (
	input  wire         clk,
	input  wire         arst_n,

	input  wire         in_valid,
	output logic        in_stall,
	input  wire         req_type,
	input  wire         has_pulse,
	input  wire         wants_completion,
	input  wire  [17:0] instr_word,
	input  wire  [17:0] ac_word,
	input  wire  [17:0] io_word,

	output logic        out_valid,
	input  wire         out_stall,
	output logic        dot_valid,
	output logic        screen,
	output logic [9:0]  dot_x,
	output logic [9:0]  dot_y,
	output logic [2:0]  dot_intensity,
	output logic        pen_check,
	output logic [9:0]  pen_radius_sq,
	output logic        complete_pulse,
	output logic        clear_pen_flag,
	output logic        last,

	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [3:0]  paddr,
	input  wire  [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	// Register indexes on paddr[3:2].
	localparam logic [1:0] REG_LIGHTPEN  = 2'd0;
	localparam logic [1:0] REG_SDB       = 2'd1;
	localparam logic [1:0] REG_SHIFT     = 2'd2;
	localparam logic [1:0] REG_TWOSCREEN = 2'd3;

	vdic_pkg::vdic_cfg_t   cfg_q;
	vdic_pkg::vdic_state_t st_q;
	vdic_pkg::vdic_state_t st_nxt;
	vdic_pkg::vdic_in_t    item_s1;
	logic                  valid_s1;

	logic [1:0]            nres;
	vdic_pkg::vdic_res_t   res0;
	vdic_pkg::vdic_res_t   res1;
	vdic_pkg::vdic_res_t   head;
	logic                  q_not_empty;
	logic                  q_room2;
	logic [vdic_pkg::QCNT_W-1:0] q_count;
	logic                  advance;
	logic                  take_in;
	logic                  pop;
	logic                  cfg_wr;
	logic [1:0]            wr_n;

	// Configuration port: zero wait states, one enable bit per register.
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_comb begin
		prdata = '0;
		case (paddr[3:2])
			REG_LIGHTPEN:  prdata[0] = cfg_q.lightpen;
			REG_SDB:       prdata[0] = cfg_q.sdb;
			REG_SHIFT:     prdata[0] = cfg_q.shift;
			REG_TWOSCREEN: prdata[0] = cfg_q.twoscreen;
			default:       prdata[0] = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_LIGHTPEN:  cfg_q.lightpen  <= pwdata[0];
				REG_SDB:       cfg_q.sdb       <= pwdata[0];
				REG_SHIFT:     cfg_q.shift     <= pwdata[0];
				REG_TWOSCREEN: cfg_q.twoscreen <= pwdata[0];
				default:       cfg_q <= cfg_q;
			endcase
		end
	end

	// The registered word is decoded when the queue can take its worst case
	// of two results; otherwise it waits and the input side is stalled.
	assign advance  = valid_s1 & q_room2;
	assign in_stall = valid_s1 & ~q_room2;
	assign take_in  = in_valid & ~in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_in) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			item_s1.req_type         <= req_type;
			item_s1.has_pulse        <= has_pulse;
			item_s1.wants_completion <= wants_completion;
			item_s1.instr_word       <= instr_word;
			item_s1.ac_word          <= ac_word;
			item_s1.io_word          <= io_word;
		end
	end

	vdic_step #(
		.MOVE_TICKS (MOVE_TICKS),
		.DRAW_TICKS (DRAW_TICKS)
	) u_step (
		.cfg  (cfg_q),
		.item (item_s1),
		.cur  (st_q),
		.nxt  (st_nxt),
		.nres (nres),
		.res0 (res0),
		.res1 (res1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.phase     <= vdic_pkg::PH_IDLE;
			st_q.countdown <= '0;
			st_q.cur_x     <= '0;
			st_q.cur_y     <= '0;
			st_q.cur_int   <= '0;
			st_q.pending   <= 1'b0;
			st_q.aperture  <= vdic_pkg::APER_RESET;
			st_q.radius_sq <= vdic_pkg::RAD_RESET;
		end else if (advance) begin
			st_q <= st_nxt;
		end
	end

	assign wr_n = advance ? nres : 2'd0;
	assign pop  = q_not_empty & ~out_stall;

	vdic_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_n      (wr_n),
		.wr0       (res0),
		.wr1       (res1),
		.pop       (pop),
		.not_empty (q_not_empty),
		.room2     (q_room2),
		.head      (head),
		.count     (q_count)
	);

	assign out_valid      = q_not_empty;
	assign dot_valid      = head.dot_valid;
	assign screen         = head.screen;
	assign dot_x          = head.dot_x;
	assign dot_y          = head.dot_y;
	assign dot_intensity  = head.dot_intensity;
	assign pen_check      = head.pen_check;
	assign pen_radius_sq  = head.pen_radius_sq;
	assign complete_pulse = head.complete_pulse;
	assign clear_pen_flag = head.clear_pen_flag;
	assign last           = head.last;

	// The queue never holds more words than it has entries.
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_count <= vdic_pkg::QCNT_W'(vdic_pkg::QDEPTH))
		else $error("result queue overflow");

	// A running countdown always belongs to a deflection or draw phase.
	a_count_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q.countdown != '0) |-> (st_q.phase != vdic_pkg::PH_IDLE))
		else $error("countdown running while idle");

	// Two results from one word only come from a two-screen dot.
	a_two_screen: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_n == 2'd2) |-> (cfg_q.twoscreen && item_s1.req_type))
		else $error("second dot without two-screen mode");

	// A stalled input is always backed by a held word in the input register.
	a_stall_held: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |=> valid_s1)
		else $error("input stalled with empty input register");

endmodule

`default_nettype wire
